[sv/bgc_pkg.sv]
// Shared constants, register indexes and event codes of the button gesture classifier.
package bgc_pkg;

  localparam int unsigned SAMPLE_COUNT   = 10;
  localparam int unsigned SAMPLE_SPACING = 2;
  localparam int unsigned SAMPLE_LIMIT   = SAMPLE_COUNT - (SAMPLE_COUNT >> 1);

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned SAMPLE_W  = 4;
  localparam int unsigned SPACING_W = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned EVENT_W   = 3;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLICK_MIN       = 3'd0,
    REG_CLICK_MAX       = 3'd1,
    REG_LONG_MIN        = 3'd2,
    REG_LONG_MAX        = 3'd3,
    REG_LONGER_MIN      = 3'd4,
    REG_LONGER_MAX      = 3'd5,
    REG_DOUBLE_WINDOW   = 3'd6,
    REG_DEBOUNCE_ENABLE = 3'd7
  } cfg_reg_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_LONGER = 3'd4
  } event_t;

endpackage

[sv/bgc_debounce.sv]
// Majority-sampling debouncer that turns the raw pin level into a stable level.
module bgc_debounce
  import bgc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic pin_level,
  input  logic enable,
  output logic level_nxt
);

  logic                 level_r;
  logic                 active_r, active_nxt;
  logic [SAMPLE_W-1:0]  taken_r, taken_nxt;
  logic [SAMPLE_W-1:0]  high_r, high_nxt;
  logic [SPACING_W-1:0] spacing_r, spacing_nxt;

  logic [SPACING_W-1:0] spacing_inc;
  logic                 do_sample;
  logic [SAMPLE_W-1:0]  base_taken, base_high;
  logic [SAMPLE_W-1:0]  smp_taken, smp_high;

  assign spacing_inc = spacing_r + SPACING_W'(1);
  assign base_taken  = active_r ? taken_r : '0;
  assign base_high   = active_r ? high_r : '0;
  assign smp_taken   = base_taken + SAMPLE_W'(1);
  assign smp_high    = base_high + SAMPLE_W'(pin_level);

  always_comb begin
    level_nxt   = level_r;
    active_nxt  = active_r;
    taken_nxt   = taken_r;
    high_nxt    = high_r;
    spacing_nxt = spacing_r;
    do_sample   = 1'b0;
    if (!enable) begin
      active_nxt  = 1'b0;
      taken_nxt   = '0;
      high_nxt    = '0;
      spacing_nxt = '0;
      level_nxt   = pin_level;
    end else if (!active_r) begin
      if (pin_level != level_r) begin
        active_nxt = 1'b1;
        do_sample  = 1'b1;
      end
    end else begin
      spacing_nxt = spacing_inc;
      do_sample   = (32'(spacing_inc) >= SAMPLE_SPACING);
    end
    if (do_sample) begin
      spacing_nxt = '0;
      taken_nxt   = smp_taken;
      high_nxt    = smp_high;
      if (32'(smp_taken) >= SAMPLE_COUNT) begin
        level_nxt  = (32'(smp_high) > SAMPLE_LIMIT);
        active_nxt = 1'b0;
        taken_nxt  = '0;
        high_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= 1'b0;
      active_r  <= 1'b0;
      taken_r   <= '0;
      high_r    <= '0;
      spacing_r <= '0;
    end else if (step) begin
      level_r   <= level_nxt;
      active_r  <= active_nxt;
      taken_r   <= taken_nxt;
      high_r    <= high_nxt;
      spacing_r <= spacing_nxt;
    end
  end

endmodule

[sv/button_gesture_classifier.sv]
// Top level of the button gesture classifier: press timing, classification and output register.
// The result of a tick transaction is registered and shown in the cycle after it is accepted.
// Throughput: one tick per cycle; in_ready drops only while a result waits on out_ready.
// The state update and the window compares sit between the input and the result register.
// Reset (synchronous, rst_n low) loads the default windows, enables debounce and
// clears the press timer, the click timer, the debouncer and the output valid flag.
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_pin_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [EVENT_W-1:0]   out_event_code,
  output logic                 out_stable_level,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  logic [TICK_W-1:0] click_min_r, click_max_r, long_min_r, long_max_r;
  logic [TICK_W-1:0] longer_min_r, longer_max_r, double_window_r;
  logic              debounce_enable_r;

  logic              pressed_r, pressed_nxt;
  logic [TICK_W-1:0] press_ticks_r, press_ticks_nxt;
  logic [TICK_W-1:0] since_click_r, since_click_nxt;

  logic              out_valid_r;
  event_t            out_event_r, event_nxt;
  logic              out_level_r;

  logic              accept;
  logic              dbc_level_nxt;
  logic [TICK_W-1:0] press_inc, since_inc;
  logic              in_click, in_long, in_longer;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_min_r       <= TICK_W'(20);
      click_max_r       <= TICK_W'(500);
      long_min_r        <= TICK_W'(1000);
      long_max_r        <= TICK_W'(3000);
      longer_min_r      <= TICK_W'(3001);
      longer_max_r      <= TICK_W'(10000);
      double_window_r   <= TICK_W'(300);
      debounce_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CLICK_MIN:       click_min_r       <= cfg_wdata;
        REG_CLICK_MAX:       click_max_r       <= cfg_wdata;
        REG_LONG_MIN:        long_min_r        <= cfg_wdata;
        REG_LONG_MAX:        long_max_r        <= cfg_wdata;
        REG_LONGER_MIN:      longer_min_r      <= cfg_wdata;
        REG_LONGER_MAX:      longer_max_r      <= cfg_wdata;
        REG_DOUBLE_WINDOW:   double_window_r   <= cfg_wdata;
        REG_DEBOUNCE_ENABLE: debounce_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  bgc_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .pin_level (in_pin_level),
    .enable    (debounce_enable_r),
    .level_nxt (dbc_level_nxt)
  );

  assign since_inc = (since_click_r != TICK_MAX) ? since_click_r + TICK_W'(1) : since_click_r;
  assign press_inc = (press_ticks_r != TICK_MAX) ? press_ticks_r + TICK_W'(1) : press_ticks_r;

  assign in_click  = (press_inc >= click_min_r) && (press_inc <= click_max_r);
  assign in_long   = (press_inc >= long_min_r) && (press_inc <= long_max_r);
  assign in_longer = (press_inc >= longer_min_r) && (press_inc <= longer_max_r);

  always_comb begin
    pressed_nxt     = pressed_r;
    press_ticks_nxt = press_ticks_r;
    since_click_nxt = since_inc;
    event_nxt       = EV_NONE;
    if (pressed_r) begin
      press_ticks_nxt = press_inc;
      if (!dbc_level_nxt) begin
        pressed_nxt = 1'b0;
        if (in_click) begin
          if (since_inc > double_window_r) begin
            event_nxt       = EV_CLICK;
            since_click_nxt = '0;
          end else begin
            event_nxt = EV_DOUBLE;
          end
        end else if (in_long) begin
          event_nxt = EV_LONG;
        end else if (in_longer) begin
          event_nxt = EV_LONGER;
        end
      end
    end else if (dbc_level_nxt) begin
      pressed_nxt     = 1'b1;
      press_ticks_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r     <= 1'b0;
      press_ticks_r <= '0;
      since_click_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        pressed_r     <= pressed_nxt;
        press_ticks_r <= press_ticks_nxt;
        since_click_r <= since_click_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_event_r <= event_nxt;
      out_level_r <= dbc_level_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_event_r;
  assign out_stable_level = out_level_r;

endmodule

[sv/bgc_checker.sv]
// Port-level assertions for the button gesture classifier and their bind.
module bgc_checker
  import bgc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [EVENT_W-1:0] out_event_code,
  input logic               out_stable_level
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code)
      && $stable(out_stable_level))
    else $error("result changed while stalled");

  // Every accepted tick transaction yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

  // Gestures are reported only on the release tick, so the stable level is low.
  a_event_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code != EV_NONE) |-> !out_stable_level)
    else $error("gesture reported while button held");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= EV_LONGER)
    else $error("event code out of range");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);
